// ===== rtl/qbf_pkg.sv =====
package qbf_pkg;

    // Subdivision limits
    localparam int MAX_DEPTH   = 5;
    localparam int STACK_SLOTS = 6;
    localparam int LEVEL_W     = 3;
    localparam int TOP_W       = $clog2(STACK_SLOTS + 1);
    localparam int IDX_W       = $clog2(STACK_SLOTS);
    localparam int COORD_W     = 32;
    localparam int DIFF_W      = COORD_W + 2;
    localparam int DEV_W       = DIFF_W + 1;

    // Flatness limit after reset: 1.0 in 16.16
    localparam logic [31:0] ONE_FIX = 32'h0001_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        point_t p1;
        point_t p2;
        point_t p3;
    } curve_t;

    typedef struct packed {
        curve_t             curve;
        logic [LEVEL_W-1:0] level;
    } stack_entry_t;

    // Shared unit results toward the sequencer
    typedef struct packed {
        point_t p12;
        point_t p23;
        point_t p123;
        logic   flat;
    } dp_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_START,
        ST_EVAL,
        ST_DECIDE,
        ST_EMIT_END
    } state_t;

    // (a + b) / 2 computed exactly, truncated toward zero
    function automatic logic signed [COORD_W-1:0] half_sum(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        s = s + {{COORD_W{1'b0}}, s[COORD_W]};
        return s[COORD_W:1];
    endfunction

    // |a + c - 2b| without overflow
    function automatic logic [DIFF_W-1:0] abs_second_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [DIFF_W-1:0] d;
        d = {{2{a[COORD_W-1]}}, a} + {{2{c[COORD_W-1]}}, c}
            - {b[COORD_W-1], b, 1'b0};
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

endpackage

// ===== rtl/qbf_if.sv =====
interface qbf_curve_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] ctrl_x;
    logic signed [31:0] ctrl_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;

    modport source (
        output valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
        output ready
    );
endinterface

interface qbf_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               last_vertex;

    modport source (
        output valid, vertex_x, vertex_y, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, vertex_x, vertex_y, last_vertex,
        output ready
    );
endinterface

// ===== rtl/qbf_dp.sv =====
module qbf_dp (
    input  logic           clk,
    input  qbf_pkg::curve_t curve,
    input  logic [31:0]    flatness_limit,
    output qbf_pkg::dp_res_t res
);
    import qbf_pkg::*;

    point_t            p12_reg;
    point_t            p23_reg;
    logic [DIFF_W-1:0] adx_reg;
    logic [DIFF_W-1:0] ady_reg;
    logic [DEV_W-1:0]  dev;

    // First phase: outer midpoints and second differences
    always_ff @(posedge clk)
    begin
        p12_reg.x <= half_sum(curve.p1.x, curve.p2.x);
        p12_reg.y <= half_sum(curve.p1.y, curve.p2.y);
        p23_reg.x <= half_sum(curve.p2.x, curve.p3.x);
        p23_reg.y <= half_sum(curve.p2.y, curve.p3.y);
        adx_reg   <= abs_second_diff(curve.p1.x, curve.p2.x, curve.p3.x);
        ady_reg   <= abs_second_diff(curve.p1.y, curve.p2.y, curve.p3.y);
    end

    // Second phase: curve midpoint and flatness compare
    assign dev = {1'b0, adx_reg} + {1'b0, ady_reg};

    always_comb
    begin
        res.p12    = p12_reg;
        res.p23    = p23_reg;
        res.p123.x = half_sum(p12_reg.x, p23_reg.x);
        res.p123.y = half_sum(p12_reg.y, p23_reg.y);
        res.flat   = (dev <= {{(DEV_W-32){1'b0}}, flatness_limit});
    end

endmodule

// ===== rtl/qbf_stack.sv =====
module qbf_stack (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      push,
    input  qbf_pkg::stack_entry_t     push_entry,
    input  logic                      pop,
    output logic [qbf_pkg::TOP_W-1:0] top,
    output qbf_pkg::stack_entry_t     rd_entry
);
    import qbf_pkg::*;

    stack_entry_t     mem [STACK_SLOTS];
    stack_entry_t     rd_entry_reg;
    logic [TOP_W-1:0] top_reg;
    logic [TOP_W-1:0] top_next;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;

    assign wr_idx = top_reg[IDX_W-1:0];
    assign rd_idx = (top_reg == '0) ? '0 : IDX_W'(top_reg - TOP_W'(1));

    // Track the number of pending subcurves
    always_comb
    begin
        top_next = top_reg;
        if (clear)
        begin
            top_next = '0;
        end
        else if (push)
        begin
            top_next = top_reg + TOP_W'(1);
        end
        else if (pop)
        begin
            top_next = top_reg - TOP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else
        begin
            top_reg <= top_next;
        end
    end

    // Write the pushed right half; read the topmost entry every cycle
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_idx] <= push_entry;
        end
        rd_entry_reg <= mem[rd_idx];
    end

    assign top      = top_reg;
    assign rd_entry = rd_entry_reg;

endmodule

// ===== rtl/quadratic_bezier_flattener_core.sv =====
// Quadratic Bezier flattener.
// A request on curve_in carries one curve as three signed 16.16 control
// points; curve_in.ready is high only while the block is idle. The block
// answers with a polyline on vertex_out: the start point, one curve midpoint
// for every flat (or depth-capped) subcurve in left-to-right order, and the
// end point with last_vertex set. Between 3 and 34 vertices per curve.
// Each subcurve is evaluated in the EVAL and DECIDE states by one shared
// midpoint and flatness unit; right halves wait on a six-entry stack. With
// k midpoints there are 2k-1 evaluations. The start point is loaded into
// the output register from the EMIT_START state once that register is free.
// vertex_out is a single output register: a stalled receiver holds the
// current vertex and the sequencer waits until the register frees up.
// flatness_limit is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset (rst_n low) returns to idle with an empty stack, no pending vertex,
// and a flatness limit of 1.0.
module quadratic_bezier_flattener_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    qbf_curve_if.sink   curve_in,
    qbf_vertex_if.source vertex_out
);
    import qbf_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    curve_t             curve_reg;
    curve_t             curve_next;
    point_t             end_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic [31:0]        limit_reg;

    logic               out_valid_reg;
    point_t             vertex_reg;
    logic               last_reg;
    logic               out_free;

    dp_res_t            res;
    stack_entry_t       push_entry;
    stack_entry_t       rd_entry;
    logic [TOP_W-1:0]   top;
    logic               stop;

    logic               in_ready;
    logic               load_in;
    logic               emit_start;
    logic               emit_mid;
    logic               emit_end;
    logic               push;
    logic               pop;

    qbf_dp u_dp (
        .clk            (clk),
        .curve          (curve_reg),
        .flatness_limit (limit_reg),
        .res            (res)
    );

    assign push_entry.curve.p1 = res.p123;
    assign push_entry.curve.p2 = res.p23;
    assign push_entry.curve.p3 = curve_reg.p3;
    assign push_entry.level    = level_reg + LEVEL_W'(1);

    qbf_stack u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (load_in),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .top        (top),
        .rd_entry   (rd_entry)
    );

    assign out_free = !out_valid_reg || vertex_out.ready;
    assign stop     = res.flat || (level_reg >= LEVEL_W'(MAX_DEPTH))
                      || (top >= TOP_W'(STACK_SLOTS));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (curve_in.valid)
                begin
                    state_next = ST_EMIT_START;
                end
            end
            ST_EMIT_START:
            begin
                if (out_free)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!stop)
                begin
                    state_next = ST_EVAL;
                end
                else if (out_free)
                begin
                    state_next = (top == '0) ? ST_EMIT_END : ST_EVAL;
                end
            end
            ST_EMIT_END:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        load_in    = 1'b0;
        emit_start = 1'b0;
        emit_mid   = 1'b0;
        emit_end   = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                load_in  = curve_in.valid;
            end
            ST_EMIT_START:
            begin
                emit_start = out_free;
            end
            ST_EVAL:
            begin
            end
            ST_DECIDE:
            begin
                push     = !stop;
                emit_mid = stop && out_free;
                pop      = stop && out_free && (top != '0);
            end
            ST_EMIT_END:
            begin
                emit_end = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Current subcurve: load, split to the left half, or pop
    always_comb
    begin
        curve_next = curve_reg;
        level_next = level_reg;
        if (load_in)
        begin
            curve_next.p1.x = curve_in.start_x;
            curve_next.p1.y = curve_in.start_y;
            curve_next.p2.x = curve_in.ctrl_x;
            curve_next.p2.y = curve_in.ctrl_y;
            curve_next.p3.x = curve_in.end_x;
            curve_next.p3.y = curve_in.end_y;
            level_next      = '0;
        end
        else if (push)
        begin
            curve_next.p2 = res.p12;
            curve_next.p3 = res.p123;
            level_next    = level_reg + LEVEL_W'(1);
        end
        else if (pop)
        begin
            curve_next = rd_entry.curve;
            level_next = rd_entry.level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            level_reg <= '0;
            limit_reg <= ONE_FIX;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // Hold curve and end point
    always_ff @(posedge clk)
    begin
        curve_reg <= curve_next;
        if (load_in)
        begin
            end_reg.x <= curve_in.end_x;
            end_reg.y <= curve_in.end_y;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_start || emit_mid || emit_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (vertex_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_start)
        begin
            vertex_reg <= curve_reg.p1;
            last_reg   <= 1'b0;
        end
        else if (emit_mid)
        begin
            vertex_reg <= res.p123;
            last_reg   <= 1'b0;
        end
        else if (emit_end)
        begin
            vertex_reg <= end_reg;
            last_reg   <= 1'b1;
        end
    end

    assign curve_in.ready         = in_ready;
    assign vertex_out.valid       = out_valid_reg;
    assign vertex_out.vertex_x    = vertex_reg.x;
    assign vertex_out.vertex_y    = vertex_reg.y;
    assign vertex_out.last_vertex = last_reg;

`ifndef SYNTHESIS
    a_stack_within_level: assert property (@(posedge clk) disable iff (!rst_n)
        top <= TOP_W'(level_reg))
        else $error("pending stack deeper than current level");

    a_level_capped: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_W'(MAX_DEPTH))
        else $error("subdivision level beyond depth cap");

    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (curve_in.valid && curve_in.ready) |=> (top == '0 && level_reg == '0))
        else $error("new curve started with stale stack or level");

    a_end_only_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        emit_end |-> (top == '0))
        else $error("end point emitted with pending subcurves");
`endif

endmodule
